FILE: sv/qat_pkg.sv
// ----------------------------------------------------------------------------
// qat_pkg
// Types and constants shared by the quote aware tokenizer modules.
// ----------------------------------------------------------------------------
package qat_pkg;

	localparam int NUM_DELIM = 4;
	localparam int MAX_RES   = 3;

	// Result kinds.
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_TEND = 2'd1;
	localparam logic [1:0] KIND_LEND = 2'd2;

	// Scanner states.
	localparam logic [1:0] ST_BETWEEN = 2'd0;
	localparam logic [1:0] ST_TOKEN   = 2'd1;
	localparam logic [1:0] ST_QUOTED  = 2'd2;

	// Special characters.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// Configuration register indexes.
	localparam logic [1:0] REG_DELIM_A = 2'd0;
	localparam logic [1:0] REG_DELIM_B = 2'd1;
	localparam logic [1:0] REG_DELIM_C = 2'd2;
	localparam logic [1:0] REG_DELIM_D = 2'd3;

	// Delimiter reset values: space, tab, carriage return, line feed.
	localparam logic [7:0] DELIM_A_RST = 8'd32;
	localparam logic [7:0] DELIM_B_RST = 8'd9;
	localparam logic [7:0] DELIM_C_RST = 8'd13;
	localparam logic [7:0] DELIM_D_RST = 8'd10;

	typedef logic [NUM_DELIM-1:0][7:0] delim_set_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
	} res_t;

	// All results caused by one input byte, in delivery order.
	typedef struct packed {
		res_t [MAX_RES-1:0] items;
		logic [1:0]         count;
	} bundle_t;

	function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] ch);
		res_t r;
		r.kind = kind;
		r.ch   = (kind == KIND_CHAR) ? ch : 8'd0;
		return r;
	endfunction

endpackage

FILE: sv/qat_in_if.sv
// ----------------------------------------------------------------------------
// qat_in_if
// Character channel: one line byte or an end-of-line marker per request.
// ----------------------------------------------------------------------------
interface qat_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_line;

	modport source (output valid, output in_byte, output end_of_line, input ready);
	modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface

FILE: sv/qat_out_if.sv
// ----------------------------------------------------------------------------
// qat_out_if
// Result channel: one token character, token end or line end per request.
// ----------------------------------------------------------------------------
interface qat_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic       last_of_run;

	modport source (output valid, output kind, output char_out, output last_of_run,
		input ready);
	modport sink   (input valid, input kind, input char_out, input last_of_run,
		output ready);
endinterface

FILE: sv/qat_scan.sv
// ----------------------------------------------------------------------------
// qat_scan
// Tokenizer state machine: turns one accepted byte into a result bundle.
// ----------------------------------------------------------------------------
module qat_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          in_byte,
	input  logic                end_of_line,
	input  qat_pkg::delim_set_t delims,
	output qat_pkg::bundle_t    bundle
);
	import qat_pkg::*;

	logic [1:0] state_q;
	logic       bs_pend_q;
	logic [1:0] state_d;
	logic       bs_pend_d;
	logic       is_delim;
	logic       eol;

	always_comb begin
		is_delim = 1'b0;
		for (int i = 0; i < NUM_DELIM; i++) begin
			if (delims[i] != 8'd0 && delims[i] == in_byte) begin
				is_delim = 1'b1;
			end
		end
	end

	assign eol = end_of_line || (in_byte == 8'd0);

	always_comb begin
		logic       plain;
		logic [1:0] n;
		plain     = 1'b0;
		n         = 2'd0;
		state_d   = state_q;
		bs_pend_d = bs_pend_q;
		bundle    = '0;
		if (eol) begin
			if (bs_pend_q) begin
				bundle.items[n] = mk_res(KIND_CHAR, CH_BSLASH);
				n = n + 2'd1;
			end
			if (state_q != ST_BETWEEN) begin
				bundle.items[n] = mk_res(KIND_TEND, 8'd0);
				n = n + 2'd1;
			end
			bundle.items[n] = mk_res(KIND_LEND, 8'd0);
			n = n + 2'd1;
			state_d   = ST_BETWEEN;
			bs_pend_d = 1'b0;
		end else if (bs_pend_q) begin
			bs_pend_d = 1'b0;
			if (in_byte == CH_QUOTE || in_byte == CH_BSLASH) begin
				bundle.items[n] = mk_res(KIND_CHAR, in_byte);
				n = n + 2'd1;
			end else begin
				// The held backslash was literal; the byte then runs normally.
				bundle.items[n] = mk_res(KIND_CHAR, CH_BSLASH);
				n = n + 2'd1;
				plain = 1'b1;
			end
		end else begin
			plain = 1'b1;
		end

		if (plain) begin
			if (state_q == ST_QUOTED) begin
				if (in_byte == CH_QUOTE) begin
					state_d = ST_TOKEN;
				end else if (in_byte == CH_BSLASH) begin
					bs_pend_d = 1'b1;
				end else begin
					bundle.items[n] = mk_res(KIND_CHAR, in_byte);
					n = n + 2'd1;
				end
			end else if (is_delim) begin
				if (state_q == ST_TOKEN) begin
					bundle.items[n] = mk_res(KIND_TEND, 8'd0);
					n = n + 2'd1;
				end
				state_d = ST_BETWEEN;
			end else begin
				state_d = ST_TOKEN;
				if (in_byte == CH_QUOTE) begin
					state_d = ST_QUOTED;
				end else if (in_byte == CH_BSLASH) begin
					bs_pend_d = 1'b1;
				end else begin
					bundle.items[n] = mk_res(KIND_CHAR, in_byte);
					n = n + 2'd1;
				end
			end
		end
		bundle.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_BETWEEN;
			bs_pend_q <= 1'b0;
		end else if (accept) begin
			state_q   <= state_d;
			bs_pend_q <= bs_pend_d;
		end
	end

endmodule

FILE: sv/qat_emit.sv
// ----------------------------------------------------------------------------
// qat_emit
// Result register: holds one bundle and hands its results out one a cycle while results.ready is high.
// ----------------------------------------------------------------------------
module qat_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  qat_pkg::bundle_t bundle,
	output logic             can_load,
	qat_out_if.source        results
);
	import qat_pkg::*;

	bundle_t    bundle_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       last;
	logic       fire;
	res_t       cur;

	assign cur  = bundle_q.items[idx_q];
	assign last = (idx_q == bundle_q.count - 2'd1);
	assign fire = valid_q && results.ready;

	// A new bundle may enter in the same cycle the final result leaves.
	assign can_load = !valid_q || (fire && last);

	assign results.valid       = valid_q;
	assign results.kind        = cur.kind;
	assign results.char_out    = cur.ch;
	assign results.last_of_run = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (fire) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

endmodule

FILE: sv/quote_aware_tokenizer.sv
// ----------------------------------------------------------------------------
// quote_aware_tokenizer
// Splits a byte stream of command lines into token characters and markers.
// ----------------------------------------------------------------------------
// Feed a line one nonzero byte per request on chars, then a request with
// end_of_line set (a zero byte counts as end of line too). Each request
// causes up to three results on the results channel: token characters,
// token ends and a line end, with last_of_run marking the final result of
// that request. Bytes equal to a nonzero delimiter register separate tokens;
// double quotes make delimiters literal and are themselves dropped; a
// backslash before a quote or a backslash yields that character, any other
// backslash is kept. A byte is accepted in every cycle as long as its
// predecessor caused at most one result and the result channel is ready; a
// byte whose predecessor caused k results waits until the result register
// has delivered all k. The pace is set by the single result register, which
// delivers one result a cycle while the result channel is ready.
// Delimiter registers reset to space, tab, carriage return and line feed and
// should be written only while no line is in flight.
// ----------------------------------------------------------------------------
module quote_aware_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	qat_in_if.sink     chars,
	qat_out_if.source  results
);
	import qat_pkg::*;

	delim_set_t delims_q;
	bundle_t    bundle;
	logic       can_load;
	logic       accept;

	// Configuration registers. The index covers exactly the four delimiters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delims_q[0] <= DELIM_A_RST;
			delims_q[1] <= DELIM_B_RST;
			delims_q[2] <= DELIM_C_RST;
			delims_q[3] <= DELIM_D_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELIM_A: delims_q[0] <= cfg_data;
				REG_DELIM_B: delims_q[1] <= cfg_data;
				REG_DELIM_C: delims_q[2] <= cfg_data;
				REG_DELIM_D: delims_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A request is taken whenever the result register can take its bundle.
	assign chars.ready = can_load;
	assign accept      = chars.valid && can_load;

	qat_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (chars.in_byte),
		.end_of_line (chars.end_of_line),
		.delims      (delims_q),
		.bundle      (bundle)
	);

	// Requests that cause no result (skipped delimiters, quote marks, a
	// held backslash) leave the result register untouched.
	qat_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && (bundle.count != 2'd0)),
		.bundle   (bundle),
		.can_load (can_load),
		.results  (results)
	);

endmodule

FILE: bench/qat_token_checker.sv
// ----------------------------------------------------------------------------
// qat_token_checker
// Watches both channels of the tokenizer and checks every result in order.
// It mirrors the delimiter writes, predicts the results of each accepted
// request and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module qat_token_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	qat_in_if          chars,
	qat_out_if         results,
	output int         fail_count,
	output int         pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import qat_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
		logic       last;
	} token_res_t;

	token_res_t pending_results[$];
	token_res_t want;
	delim_set_t delims;
	logic [1:0] scan_state;
	logic       bs_wait;
	int         mismatches;

	function automatic logic is_separator(input logic [7:0] c);
		logic hit = 1'b0;
		for (int i = 0; i < NUM_DELIM; i++) begin
			if (c == delims[i])
				hit = 1'b1;
		end
		return hit && (c != 8'd0);
	endfunction

	function automatic void emit(input logic [1:0] kind, input logic [7:0] ch);
		token_res_t r;
		r.kind = kind;
		r.ch   = (kind == KIND_CHAR) ? ch : 8'd0;
		r.last = 1'b0;
		pending_results.push_back(r);
	endfunction

	// Handles a byte when no backslash is waiting for its successor.
	function automatic void scan_plain(input logic [7:0] c);
		if (scan_state == ST_QUOTED) begin
			if (c == CH_QUOTE)
				scan_state = ST_TOKEN;
			else if (c == CH_BSLASH)
				bs_wait = 1'b1;
			else
				emit(KIND_CHAR, c);
		end else if (is_separator(c)) begin
			if (scan_state == ST_TOKEN)
				emit(KIND_TEND, 8'd0);
			scan_state = ST_BETWEEN;
		end else if (c == CH_QUOTE) begin
			scan_state = ST_QUOTED;
		end else begin
			scan_state = ST_TOKEN;
			if (c == CH_BSLASH)
				bs_wait = 1'b1;
			else
				emit(KIND_CHAR, c);
		end
	endfunction

	function automatic void tokenize_request(input logic [7:0] c, input logic eol_flag);
		int base;
		base = pending_results.size();
		if (eol_flag || (c == 8'd0)) begin
			if (bs_wait)
				emit(KIND_CHAR, CH_BSLASH);
			if (scan_state != ST_BETWEEN)
				emit(KIND_TEND, 8'd0);
			emit(KIND_LEND, 8'd0);
			scan_state = ST_BETWEEN;
			bs_wait    = 1'b0;
		end else if (bs_wait) begin
			bs_wait = 1'b0;
			if ((c == CH_QUOTE) || (c == CH_BSLASH)) begin
				emit(KIND_CHAR, c);
			end else begin
				emit(KIND_CHAR, CH_BSLASH);
				scan_plain(c);
			end
		end else begin
			scan_plain(c);
		end
		if (pending_results.size() > base)
			pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delims        = {DELIM_D_RST, DELIM_C_RST, DELIM_B_RST, DELIM_A_RST};
			scan_state    = ST_BETWEEN;
			bs_wait       = 1'b0;
			mismatches    = 0;
			pending_results.delete();
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DELIM_A: delims[0] = cfg_data;
					REG_DELIM_B: delims[1] = cfg_data;
					REG_DELIM_C: delims[2] = cfg_data;
					REG_DELIM_D: delims[3] = cfg_data;
					default: ;
				endcase
			end

			// Predict before comparing, so a result can never overtake its request.
			if (chars.valid && chars.ready)
				tokenize_request(chars.in_byte, chars.end_of_line);

			if (results.valid && results.ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind %0d char %02h last %0b",
							results.kind, results.char_out, results.last_of_run);
				end else begin
					want = pending_results.pop_front();
					if ((results.kind !== want.kind) || (results.char_out !== want.ch) ||
						(results.last_of_run !== want.last)) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected kind %0d char %02h ",
								"last %0b, got kind %0d char %02h last %0b"},
								want.kind, want.ch, want.last,
								results.kind, results.char_out, results.last_of_run);
					end
				end
			end

			fail_count    <= mismatches;
			pending_count <= pending_results.size();
		end
	end

endmodule

FILE: bench/quote_aware_tokenizer_test.sv
// ----------------------------------------------------------------------------
// quote_aware_tokenizer_test
// Stimulus and verdict for the quote aware tokenizer.
// Short directed lines cover quotes, escapes and line ends; then random
// command lines run under several delimiter settings with random stalls on
// both channels (none in the last) and one long hold-off of the result channel.
// ----------------------------------------------------------------------------
module quote_aware_tokenizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import qat_pkg::*;

	// Watchdog limit, well above the length of the slowest correct run.
	localparam int CYCLE_LIMIT     = 200000;
	// Length of the one long stall of the result channel.
	localparam int HOLD_OFF_CYCLES = 200;
	// Cycles allowed after the last expected result before a register write,
	// since a request may cause no result while the block is still busy.
	localparam int SETTLE_CYCLES   = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       eol;
	} char_req_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	qat_in_if  chars_if();
	qat_out_if results_if();

	int         fail_count;
	int         pending_count;

	// Requests waiting to be offered on the character channel.
	char_req_t  line_fifo[$];
	char_req_t  head_req;
	int         queued_count;
	int         taken_count;
	int         send_gap;
	int         recv_gap;
	logic       idle_on;
	logic       long_stall;
	// The delimiter setting last written, used to make delimiters frequent.
	delim_set_t cur_delim;

	quote_aware_tokenizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chars     (chars_if),
		.results   (results_if)
	);

	qat_token_checker token_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.chars         (chars_if),
		.results       (results_if),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sender. A new request is loaded whenever the current one has been taken
	// or none is on offer. Idle bursts fall at random in between, and only
	// while idle_on is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid       <= 1'b0;
			chars_if.in_byte     <= 8'd0;
			chars_if.end_of_line <= 1'b0;
			send_gap             <= 0;
			taken_count          <= 0;
		end else begin
			if (chars_if.valid && chars_if.ready)
				taken_count <= taken_count + 1;
			if (!chars_if.valid || chars_if.ready) begin
				if (send_gap > 0) begin
					chars_if.valid <= 1'b0;
					send_gap       <= send_gap - 1;
				end else if (idle_on && (line_fifo.size() > 0) &&
					($urandom_range(0, 7) == 0)) begin
					chars_if.valid <= 1'b0;
					send_gap       <= int'($urandom_range(0, 14));
				end else if (line_fifo.size() > 0) begin
					head_req             = line_fifo.pop_front();
					chars_if.valid       <= 1'b1;
					chars_if.in_byte     <= head_req.data;
					chars_if.end_of_line <= head_req.eol;
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Ready drops for random bursts while idle_on is set, and for the
	// whole of the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			recv_gap         <= 0;
		end else if (long_stall) begin
			results_if.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			results_if.ready <= 1'b0;
			recv_gap         <= recv_gap - 1;
		end else if (idle_on && ($urandom_range(0, 9) == 0)) begin
			results_if.ready <= 1'b0;
			recv_gap         <= int'($urandom_range(0, 14));
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	// Long hold-off: once the random lines are flowing, the receiver stops
	// for a fixed stretch while the sender keeps offering requests, so the
	// single result register fills and the character channel must stall.
	initial begin
		long_stall <= 1'b0;
		wait (taken_count >= 60);
		@(posedge clk);
		long_stall <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		long_stall <= 1'b0;
	end

	// Watchdog: a run that has not ended by now has hung.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic queue_req(input logic [7:0] data, input logic eol);
		line_fifo.push_back('{data, eol});
		queued_count++;
	endtask

	// Writes one delimiter register; only called while the block is idle.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_delim[idx] = val;
	endtask

	// Waits until every request has been taken and every predicted result has
	// arrived, then waits out the settle time of SETTLE_CYCLES as well.
	task automatic drain();
		while (taken_count != queued_count) @(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A character for a well-formed line: delimiters, quotes and backslashes
	// are frequent so that every scanner state is visited often.
	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1: c = cur_delim[2'($urandom_range(0, 3))];
			2: c = CH_QUOTE;
			3: c = CH_BSLASH;
			8, 9: c = 8'($urandom_range(1, 255));
			default: c = 8'h61 + 8'($urandom_range(0, 25));
		endcase
		// A zero register would give a zero byte, which ends the line.
		if (c == 8'd0)
			c = 8'h7A;
		return c;
	endfunction

	// Queues random command lines until about n_reqs requests are waiting.
	// Most lines are well formed; about one in ten is raw noise in which a
	// zero byte or a set end_of_line flag may end the line early.
	task automatic gen_lines(input int n_reqs);
		int made;
		int len;
		logic noisy;
		made = 0;
		while (made < n_reqs) begin
			len   = ($urandom_range(0, 7) == 0) ? int'($urandom_range(13, 30)) :
				int'($urandom_range(0, 12));
			noisy = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < len; i++) begin
				if (noisy)
					queue_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else
					queue_req(pick_char(), 1'b0);
				made++;
			end
			// Close the line with the end flag, or now and then a zero byte.
			if ($urandom_range(0, 5) == 0)
				queue_req(8'd0, 1'b0);
			else
				queue_req(8'($urandom_range(0, 255)), 1'b1);
			made++;
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_DELIM_A;
		cfg_data     <= 8'd0;
		idle_on      <= 1'b1;
		cur_delim    = {DELIM_D_RST, DELIM_C_RST, DELIM_B_RST, DELIM_A_RST};
		queued_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed line with the reset delimiters: a leading delimiter, the
		// smallest nonzero and largest bytes, empty quotes that still make a token,
		// both escapes, a literal backslash, an escaped quote inside quotes
		// and a quote left open up to the end of the line.
		queue_req(8'h20, 1'b0);
		queue_req(8'h01, 1'b0);
		queue_req(8'hFF, 1'b0);
		queue_req(8'h09, 1'b0);
		queue_req(CH_QUOTE, 1'b0);
		queue_req(CH_QUOTE, 1'b0);
		queue_req(8'h0D, 1'b0);
		queue_req(CH_BSLASH, 1'b0);
		queue_req(CH_QUOTE, 1'b0);
		queue_req(CH_BSLASH, 1'b0);
		queue_req(CH_BSLASH, 1'b0);
		queue_req(CH_BSLASH, 1'b0);
		queue_req(8'h61, 1'b0);
		queue_req(8'h0A, 1'b0);
		queue_req(CH_QUOTE, 1'b0);
		queue_req(8'h78, 1'b0);
		queue_req(8'h20, 1'b0);
		queue_req(CH_BSLASH, 1'b0);
		queue_req(CH_QUOTE, 1'b0);
		queue_req(8'h41, 1'b1);
		// A backslash left waiting when a zero byte ends the line.
		queue_req(CH_BSLASH, 1'b0);
		queue_req(8'd0, 1'b0);
		// A backslash followed by a delimiter, then an empty line.
		queue_req(CH_BSLASH, 1'b0);
		queue_req(8'h20, 1'b0);
		queue_req(8'hFF, 1'b1);
		queue_req(8'h00, 1'b1);
		drain();

		// Random lines with the reset delimiters; the long hold-off falls here.
		gen_lines(120);
		drain();

		// Backslash as a delimiter and two unused registers: the backslash
		// only waits inside quotes, where a delimiter after it must resolve it.
		write_reg(REG_DELIM_A, CH_BSLASH);
		write_reg(REG_DELIM_B, 8'h00);
		write_reg(REG_DELIM_C, 8'h20);
		write_reg(REG_DELIM_D, 8'h00);
		gen_lines(100);
		drain();

		// Quote as a delimiter, so quoting is switched off, with the largest
		// and smallest nonzero values in the other registers.
		write_reg(REG_DELIM_A, 8'hFF);
		write_reg(REG_DELIM_B, CH_QUOTE);
		write_reg(REG_DELIM_C, 8'hFF);
		write_reg(REG_DELIM_D, 8'h01);
		gen_lines(100);
		drain();

		// Random delimiters, and no idling on either side for the last part.
		write_reg(REG_DELIM_A, 8'($urandom_range(0, 255)));
		write_reg(REG_DELIM_B, 8'($urandom_range(0, 255)));
		write_reg(REG_DELIM_C, 8'($urandom_range(0, 255)));
		write_reg(REG_DELIM_D, 8'($urandom_range(0, 255)));
		idle_on <= 1'b0;
		gen_lines(110);
		drain();

		repeat (20) @(posedge clk);
		if ((fail_count == 0) && (pending_count == 0))
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
